@@ rtl/framebuffer_glyph_rasterizer_core_assert.svh @@
// Assertion macros for the glyph rasterizer core.
// Depends on nothing; included by the modules that assert.
`ifndef FRAMEBUFFER_GLYPH_RASTERIZER_CORE_ASSERT_SVH
`define FRAMEBUFFER_GLYPH_RASTERIZER_CORE_ASSERT_SVH
// Assert an implication, disabled during reset.
`define FGR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert a condition in the cycle after a trigger.
`define FGR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/fgr_pkg.sv @@
// Shared types, constants and the 5x7 font table for the glyph rasterizer.
// No dependencies.
package fgr_pkg;
  localparam int PanelWidth  = 800;
  localparam int PanelHeight = 480;
  localparam int RowBytes    = PanelWidth / 8;
  localparam int StoreBytes  = (PanelWidth * PanelHeight) / 8;
  localparam int AddrW       = $clog2(StoreBytes);

  localparam logic [2:0] MODE_CLEAR = 3'd0;
  localparam logic [2:0] MODE_PIXEL = 3'd1;
  localparam logic [2:0] MODE_RECT  = 3'd2;
  localparam logic [2:0] MODE_CHAR  = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd90;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic signed [11:0] rect_width;
    logic signed [11:0] rect_height;
    logic               color;
    logic [7:0]         char_code;
    logic [3:0]         scale;
    logic [15:0]        byte_address;
  } fgr_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ignored;
  } fgr_out_t;

  // Dot request from the sequencer to the pixel writer.
  typedef struct packed {
    logic               vld;
    logic signed [13:0] lx;
    logic signed [13:0] ly;
    logic               white;
  } fgr_dot_t;

  // Font column bits: idx is code - 32, col picks one of five columns, column 0 in the top byte.
  function automatic logic [7:0] glyph_col(input logic [5:0] idx, input logic [2:0] col);
    logic [39:0] g;
    case (idx)
      6'd0:  g = 40'h0000000000; 6'd1:  g = 40'h00005f0000; 6'd2:  g = 40'h0007000700;
      6'd3:  g = 40'h147f147f14; 6'd4:  g = 40'h242a7f2a12; 6'd5:  g = 40'h2313086462;
      6'd6:  g = 40'h3649552250; 6'd7:  g = 40'h0005030000; 6'd8:  g = 40'h001c224100;
      6'd9:  g = 40'h0041221c00; 6'd10: g = 40'h14083e0814; 6'd11: g = 40'h08083e0808;
      6'd12: g = 40'h0050300000; 6'd13: g = 40'h0808080808; 6'd14: g = 40'h0060600000;
      6'd15: g = 40'h2010080402; 6'd16: g = 40'h3e5149453e; 6'd17: g = 40'h00427f4000;
      6'd18: g = 40'h4261514946; 6'd19: g = 40'h2141454b31; 6'd20: g = 40'h1814127f10;
      6'd21: g = 40'h2745454539; 6'd22: g = 40'h3c4a494930; 6'd23: g = 40'h0171090503;
      6'd24: g = 40'h3649494936; 6'd25: g = 40'h064949291e; 6'd26: g = 40'h0036360000;
      6'd27: g = 40'h0056360000; 6'd28: g = 40'h0814224100; 6'd29: g = 40'h1414141414;
      6'd30: g = 40'h0041221408; 6'd31: g = 40'h0201510906; 6'd32: g = 40'h324979413e;
      6'd33: g = 40'h7e1111117e; 6'd34: g = 40'h7f49494936; 6'd35: g = 40'h3e41414122;
      6'd36: g = 40'h7f4141221c; 6'd37: g = 40'h7f49494941; 6'd38: g = 40'h7f09090901;
      6'd39: g = 40'h3e4149497a; 6'd40: g = 40'h7f0808087f; 6'd41: g = 40'h00417f4100;
      6'd42: g = 40'h2040413f01; 6'd43: g = 40'h7f08142241; 6'd44: g = 40'h7f40404040;
      6'd45: g = 40'h7f020c027f; 6'd46: g = 40'h7f0408107f; 6'd47: g = 40'h3e4141413e;
      6'd48: g = 40'h7f09090906; 6'd49: g = 40'h3e4151215e; 6'd50: g = 40'h7f09192946;
      6'd51: g = 40'h4649494931; 6'd52: g = 40'h01017f0101; 6'd53: g = 40'h3f4040403f;
      6'd54: g = 40'h1f2040201f; 6'd55: g = 40'h3f4038403f; 6'd56: g = 40'h6314081463;
      6'd57: g = 40'h0708700807; 6'd58: g = 40'h6151494543;
      default: g = 40'h0;
    endcase
    case (col)
      3'd0: glyph_col = g[39:32];
      3'd1: glyph_col = g[31:24];
      3'd2: glyph_col = g[23:16];
      3'd3: glyph_col = g[15:8];
      default: glyph_col = g[7:0];
    endcase
  endfunction
endpackage

@@ rtl/framebuffer_glyph_rasterizer_core.sv @@
// Top level: command sequencer, clear sweep and output register; uses fgr_pkg and fgr_pixel_writer.
// Clear sweeps all StoreBytes entries one byte per cycle.
// One request in flight; the next is taken the cycle after the result is accepted.
// Reset: sweeps the store to white with in_ready low, then no result.
`include "framebuffer_glyph_rasterizer_core_assert.svh"
module framebuffer_glyph_rasterizer_core import fgr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic     in_valid,
  output logic     in_ready,
  input  fgr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fgr_out_t out_data
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_RECT  = 3'd2;
  localparam logic [2:0] ST_CHAR  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic [1:0] rot_r;
  fgr_in_t    req_r;
  fgr_in_t    req_in;
  logic       boot_r;   // sweep after reset owes no result
  logic [AddrW-1:0] fcnt_r;
  logic [7:0] fdata_r;
  logic [12:0] k_r;      // rectangle step
  logic [1:0]  edge_r;   // which rectangle pass
  logic [2:0]  col_r, row_r;
  logic [3:0]  dx_r, dy_r;
  logic [1:0]  drain_r;
  logic        out_vld_r;
  fgr_out_t    out_r;
  fgr_dot_t    dot;
  logic        busy;
  logic [7:0]  rd_data;
  logic        rd_en;

  assign in_ready  = (st_r == ST_IDLE) && !out_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // rotation register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r <= 2'd0;
    end else if (cfg_we) begin
      rot_r <= cfg_wdata;
    end
  end

  // pixel runs as a 1x1 outline, last edge only
  always_comb begin
    req_in = in_data;
    if (in_data.mode == MODE_PIXEL) begin
      req_in.rect_width  = 12'sd1;
      req_in.rect_height = 12'sd1;
    end
  end

  // rectangle extents, glyph column bits and character dot position
  logic signed [13:0] xw1, yh1, span, kk;
  logic [7:0] bits;
  logic signed [13:0] cx, cy;
  always_comb begin
    xw1  = 14'(req_r.pos_x) + 14'(req_r.rect_width) - 14'sd1;
    yh1  = 14'(req_r.pos_y) + 14'(req_r.rect_height) - 14'sd1;
    span = edge_r[1] ? 14'(req_r.rect_height) : 14'(req_r.rect_width);
    kk   = 14'(k_r);
    bits = glyph_col(6'(req_r.char_code - FIRST_CODE), col_r);
    cx = 14'(req_r.pos_x) + 14'(col_r) * 14'(req_r.scale) + 14'(dx_r);
    cy = 14'(req_r.pos_y) + 14'(row_r) * 14'(req_r.scale) + 14'(dy_r);
  end

  // dot generation
  always_comb begin
    dot = '0;
    dot.white = req_r.color;
    unique case (st_r)
      ST_RECT: begin
        dot.vld = (kk < span);
        unique case (edge_r)
          2'd0: begin dot.lx = 14'(req_r.pos_x) + kk; dot.ly = 14'(req_r.pos_y); end
          2'd1: begin dot.lx = 14'(req_r.pos_x) + kk; dot.ly = yh1; end
          2'd2: begin dot.lx = 14'(req_r.pos_x); dot.ly = 14'(req_r.pos_y) + kk; end
          default: begin dot.lx = xw1; dot.ly = 14'(req_r.pos_y) + kk; end
        endcase
      end
      ST_CHAR: begin
        dot.vld = bits[row_r] && (req_r.scale != 4'd0);
        dot.lx = cx;
        dot.ly = cy;
        dot.white = 1'b0;
      end
      default: ;
    endcase
  end

  assign rd_en = (st_r == ST_READ);

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (in_data.mode) inside
            MODE_CLEAR: st_nxt = ST_FILL;
            MODE_PIXEL, MODE_RECT: st_nxt = ST_RECT;
            MODE_CHAR: st_nxt = (in_data.char_code < FIRST_CODE ||
                                 in_data.char_code > LAST_CODE) ? ST_DRAIN : ST_CHAR;
            MODE_READ: st_nxt = ST_READ;
            default: st_nxt = ST_DRAIN;
          endcase
        end
      end
      ST_FILL:  if (fcnt_r == AddrW'(StoreBytes - 1)) st_nxt = boot_r ? ST_IDLE : ST_DRAIN;
      ST_RECT:  if (kk >= span - 14'sd1 && edge_r == 2'd3) st_nxt = ST_DRAIN;
      ST_CHAR:  if (col_r == 3'd4 && row_r == 3'd7 && (req_r.scale == 4'd0 ||
                    (dx_r == req_r.scale - 4'd1 && dy_r == req_r.scale - 4'd1)))
                  st_nxt = ST_DRAIN;
      ST_READ:  st_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r == 2'd2 && !busy) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_FILL;
      boot_r    <= 1'b1;
      fcnt_r    <= '0;
      fdata_r   <= 8'hFF;
      out_vld_r <= 1'b0;
      drain_r   <= '0;
      k_r <= '0; edge_r <= '0; col_r <= '0; row_r <= '0; dx_r <= '0; dy_r <= '0;
      req_r     <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_vld_r && out_ready) out_vld_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            req_r   <= req_in;
            fcnt_r  <= '0;
            fdata_r <= in_data.color ? 8'hFF : 8'h00;
            k_r <= '0; col_r <= '0; row_r <= '0; dx_r <= '0; dy_r <= '0;
            drain_r <= '0;
            // pixel runs as a 1x1 right edge only
            edge_r <= (in_data.mode == MODE_PIXEL) ? 2'd3 : 2'd0;
          end
        end
        ST_FILL: begin
          fcnt_r <= fcnt_r + AddrW'(1);
          if (st_nxt != ST_FILL) boot_r <= 1'b0;
        end
        ST_RECT: begin
          if (kk >= span - 14'sd1) begin
            k_r <= '0;
            edge_r <= edge_r + 2'd1;
          end else begin
            k_r <= k_r + 13'd1;
          end
        end
        ST_CHAR: begin
          // advance dy, dx, row, col
          if (req_r.scale == 4'd0 || dy_r == req_r.scale - 4'd1) begin
            dy_r <= '0;
            if (req_r.scale == 4'd0 || dx_r == req_r.scale - 4'd1) begin
              dx_r <= '0;
              row_r <= row_r + 3'd1;
              if (row_r == 3'd7) col_r <= col_r + 3'd1;
            end else begin
              dx_r <= dx_r + 4'd1;
            end
          end else begin
            dy_r <= dy_r + 4'd1;
          end
        end
        ST_DRAIN: begin
          if (drain_r != 2'd2) drain_r <= drain_r + 2'd1;
          if (st_nxt == ST_IDLE) begin
            out_vld_r <= 1'b1;
            out_r.ignored <= (req_r.mode == MODE_CHAR) &&
              (req_r.char_code < FIRST_CODE || req_r.char_code > LAST_CODE);
          end
        end
        default: ;
      endcase
      // capture read data in the cycle after the read
      if (st_r == ST_DRAIN && drain_r == 2'd0) begin
        out_r.read_data <= (req_r.mode == MODE_READ &&
                            req_r.byte_address < 16'(StoreBytes)) ? rd_data : 8'h00;
      end
    end
  end

  fgr_pixel_writer u_pix (
    .clk(clk), .rst_n(rst_n), .rotation(rot_r), .dot(dot),
    .fill_en(st_r == ST_FILL), .fill_addr(fcnt_r), .fill_data(fdata_r),
    .rd_en(rd_en), .rd_addr(req_r.byte_address[AddrW-1:0]),
    .rd_data(rd_data), .busy(busy)
  );

  `FGR_ASSERT_IMP(a_out_hold, out_vld_r && !out_ready, !in_ready)
  `FGR_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, st_r != ST_IDLE)
  `FGR_ASSERT_IMP(a_fill_no_dot, st_r == ST_FILL, !dot.vld)
endmodule

@@ rtl/fgr_pixel_writer.sv @@
// Frame store and its read-modify-write pipe: dot in, byte updated.
// Depends on fgr_pkg and the assertion header.
`include "framebuffer_glyph_rasterizer_core_assert.svh"
module fgr_pixel_writer import fgr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       rotation,
  input  fgr_dot_t         dot,
  // bulk write port (clear sweep) and read port (read mode)
  input  logic             fill_en,
  input  logic [AddrW-1:0] fill_addr,
  input  logic [7:0]       fill_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [7:0]       rd_data,
  output logic             busy
);
  logic [7:0] mem [StoreBytes];
  logic [7:0] q_r;

  // stage 0: clip and map to byte address and bit
  logic signed [13:0] lw, lh, px, py;
  logic [11:0] mx;
  logic [21:0] at;
  logic in_rng;
  always_comb begin
    lw = rotation[0] ? 14'(PanelHeight) : 14'(PanelWidth);
    lh = rotation[0] ? 14'(PanelWidth) : 14'(PanelHeight);
    in_rng = !dot.lx[13] && !dot.ly[13] && (dot.lx < lw) && (dot.ly < lh);
    case (rotation)
      2'd1: begin px = dot.ly; py = 14'(PanelHeight - 1) - dot.lx; end
      2'd2: begin px = 14'(PanelWidth - 1) - dot.lx; py = 14'(PanelHeight - 1) - dot.ly; end
      2'd3: begin px = 14'(PanelWidth - 1) - dot.ly; py = dot.lx; end
      default: begin px = dot.lx; py = dot.ly; end
    endcase
    mx = 12'(14'(PanelWidth - 1) - px);
    at = 22'(py[11:0]) * 22'(RowBytes) + 22'(mx[11:3]);
  end

  // stage 1 holds the pending write while the read returns
  logic             s1_vld_r, s1_vld_nxt;
  logic [AddrW-1:0] s1_addr_r;
  logic [2:0]       s1_bit_r;
  logic             s1_white_r;
  logic             fwd_r;
  logic [7:0]       last_wr_r;
  logic [7:0]       cur, wr_byte;
  logic             hit;

  assign s1_vld_nxt = dot.vld && in_rng && (at < 22'(StoreBytes));
  // the previous write lands in the same cycle as this read: forward it
  assign hit = s1_vld_r && s1_vld_nxt && (s1_addr_r == at[AddrW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    s1_addr_r  <= at[AddrW-1:0];
    s1_bit_r   <= mx[2:0];
    s1_white_r <= dot.white;
    fwd_r      <= hit;
    last_wr_r  <= wr_byte;
  end

  // modify the returned byte, MSB first
  always_comb begin
    cur = fwd_r ? last_wr_r : q_r;
    wr_byte = cur;
    wr_byte[3'd7 - s1_bit_r] = s1_white_r;
  end

  // single memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      mem[s1_addr_r] <= wr_byte;
    end else if (fill_en) begin
      mem[fill_addr] <= fill_data;
    end
    q_r <= mem[rd_en ? rd_addr : at[AddrW-1:0]];
  end

  assign rd_data = q_r;
  assign busy    = s1_vld_r;

  `FGR_ASSERT_IMP(a_no_fill_clash, fill_en, !s1_vld_r)
  `FGR_ASSERT_NEXT(a_dot_reaches_s1, s1_vld_nxt, s1_vld_r)
  `FGR_ASSERT_IMP(a_no_read_clash, rd_en, !dot.vld)
endmodule

@@ sim/tb_framebuffer_glyph_rasterizer_core.sv @@
// Testbench for framebuffer_glyph_rasterizer_core: drives commands, predicts the
// frame store and each result in a local model, and checks every result in order.
// Depends on fgr_pkg and the core RTL.
module tb_framebuffer_glyph_rasterizer_core import fgr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxMismatchReports = 10;

  // Font columns, code 32 first, column 0 in the top byte
  localparam logic [39:0] FONT_ROWS [59] = '{
    40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
    40'h14083e0814, 40'h08083e0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
    40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503, 40'h3649494936,
    40'h064949291e, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413e, 40'h7e1111117e, 40'h7f49494936,
    40'h3e41414122, 40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
    40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e, 40'h7f09090906, 40'h3e4151215e,
    40'h7f09192946, 40'h4649494931, 40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f,
    40'h3f4038403f, 40'h6314081463, 40'h0708700807, 40'h6151494543
  };

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  logic [1:0] cfg_wdata;
  logic     in_valid;
  logic     in_ready;
  fgr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  fgr_out_t out_data;

  // Model state: frame image, rotation and the results still owed
  logic [7:0] frame_image [StoreBytes];
  logic [1:0] rotation_q;
  fgr_out_t   pending_results [$];
  int         touched_bytes [$];
  int         mismatches;
  int         send_idle_pct;
  int         stall_pct;
  int         clears_left;

  framebuffer_glyph_rasterizer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Set or clear one logical dot after clipping and rotation
  function automatic void paint_dot(int lx, int ly, logic white);
    int lw, lh, px, py, mx, at;
    lw = rotation_q[0] ? PanelHeight : PanelWidth;
    lh = rotation_q[0] ? PanelWidth : PanelHeight;
    if (lx < 0 || ly < 0 || lx >= lw || ly >= lh) return;
    case (rotation_q)
      2'd1: begin px = ly; py = PanelHeight - 1 - lx; end
      2'd2: begin px = PanelWidth - 1 - lx; py = PanelHeight - 1 - ly; end
      2'd3: begin px = PanelWidth - 1 - ly; py = lx; end
      default: begin px = lx; py = ly; end
    endcase
    mx = PanelWidth - 1 - px;
    at = py * RowBytes + mx / 8;
    if (at >= StoreBytes) return;
    if (white) frame_image[at] = frame_image[at] | (8'h80 >> (mx % 8));
    else frame_image[at] = frame_image[at] & ~(8'h80 >> (mx % 8));
    touched_bytes.push_back(at);
    if (touched_bytes.size() > 64) void'(touched_bytes.pop_front());
  endfunction

  // Apply one command to the model and return the result it owes
  function automatic fgr_out_t rasterize_command(fgr_in_t cmd);
    fgr_out_t res;
    int x, y, w, h, k, col, row, dx, dy, mag;
    logic [7:0] bits;
    res = '0;
    x = cmd.pos_x;
    y = cmd.pos_y;
    w = cmd.rect_width;
    h = cmd.rect_height;
    mag = cmd.scale;
    case (cmd.mode)
      MODE_CLEAR: begin
        foreach (frame_image[i]) frame_image[i] = cmd.color ? 8'hFF : 8'h00;
      end
      MODE_PIXEL: paint_dot(x, y, cmd.color);
      MODE_RECT: begin
        for (k = x; k < x + w; k++) begin
          paint_dot(k, y, cmd.color);
          paint_dot(k, y + h - 1, cmd.color);
        end
        for (k = y; k < y + h; k++) begin
          paint_dot(x, k, cmd.color);
          paint_dot(x + w - 1, k, cmd.color);
        end
      end
      MODE_CHAR: begin
        if (cmd.char_code < FIRST_CODE || cmd.char_code > LAST_CODE) begin
          res.ignored = 1'b1;
        end else begin
          for (col = 0; col < 5; col++) begin
            bits = FONT_ROWS[cmd.char_code - FIRST_CODE][39 - 8 * col -: 8];
            for (row = 0; row < 8; row++) begin
              if (!bits[row]) continue;
              for (dx = 0; dx < mag; dx++)
                for (dy = 0; dy < mag; dy++)
                  paint_dot(x + col * mag + dx, y + row * mag + dy, 1'b0);
            end
          end
        end
      end
      MODE_READ: begin
        if (cmd.byte_address < StoreBytes) res.read_data = frame_image[cmd.byte_address];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Send one request: optional idle gap, hold until accepted, then predict
  task automatic send_command(fgr_in_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(rasterize_command(cmd));
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rotation(logic [1:0] rot);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= rot;
    @(posedge clk);
    cfg_we     <= 1'b0;
    rotation_q = rot;
  endtask

  function automatic fgr_in_t blank_command(logic [2:0] mode);
    fgr_in_t cmd;
    cmd = '0;
    cmd.mode = mode;
    return cmd;
  endfunction

  // Coordinate mostly on the panel, sometimes just off it, rarely anywhere
  function automatic logic [11:0] pick_coord(int limit);
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) return 12'($urandom_range(limit - 1));
    if (sel < 88) return 12'(-$urandom_range(8, 1));
    if (sel < 95) return 12'(limit + $urandom_range(7));
    return 12'($urandom_range(4095));
  endfunction

  function automatic fgr_in_t random_command();
    fgr_in_t cmd;
    int sel, lw, lh;
    lw = rotation_q[0] ? PanelHeight : PanelWidth;
    lh = rotation_q[0] ? PanelWidth : PanelHeight;
    cmd = '0;
    cmd.pos_x = pick_coord(lw);
    cmd.pos_y = pick_coord(lh);
    cmd.color = 1'($urandom_range(1));
    cmd.byte_address = 16'($urandom_range(65535));
    cmd.char_code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
    cmd.scale = 4'($urandom_range(1, 3));
    cmd.rect_width = 12'($urandom_range(40) - 3);
    cmd.rect_height = 12'($urandom_range(40) - 3);
    sel = $urandom_range(999);
    if (sel < 3 && clears_left > 0) begin
      cmd.mode = MODE_CLEAR;
      clears_left--;
    end else if (sel < 300) begin
      cmd.mode = MODE_PIXEL;
    end else if (sel < 480) begin
      cmd.mode = MODE_RECT;
      // rare huge spans
      if ($urandom_range(49) == 0) cmd.rect_width = 12'($urandom_range(4095));
      if ($urandom_range(49) == 0) cmd.rect_height = 12'($urandom_range(4095));
    end else if (sel < 720) begin
      cmd.mode = MODE_CHAR;
      if ($urandom_range(9) == 0) cmd.char_code = 8'($urandom_range(255));
      if ($urandom_range(15) == 0) cmd.scale = 4'($urandom_range(15));
    end else if (sel < 980) begin
      cmd.mode = MODE_READ;
      // mostly read back bytes that were just drawn
      if (touched_bytes.size() > 0 && $urandom_range(9) < 7)
        cmd.byte_address = 16'(touched_bytes[$urandom_range(touched_bytes.size() - 1)]);
    end else begin
      cmd.mode = 3'($urandom_range(7, 5));
    end
    return cmd;
  endfunction

  // Compare each accepted result with the oldest owed one
  always @(posedge clk) begin
    fgr_out_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxMismatchReports)
          $display("unexpected result read_data=%02h ignored=%0b",
                   out_data.read_data, out_data.ignored);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.read_data !== exp_res.read_data ||
            out_data.ignored !== exp_res.ignored) begin
          mismatches++;
          if (mismatches <= MaxMismatchReports)
            $display("result mismatch: read_data exp %02h got %02h, ignored exp %0b got %0b",
                     exp_res.read_data, out_data.read_data, exp_res.ignored,
                     out_data.ignored);
        end
      end
    end
  end

  // Stall the result side at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic run_directed();
    fgr_in_t cmd;
    send_command(blank_command(MODE_READ));
    // two corners and two off-panel dots black, then read four addresses
    cmd = blank_command(MODE_PIXEL);
    send_command(cmd);
    cmd.pos_x = 12'(PanelWidth - 1);
    cmd.pos_y = 12'(PanelHeight - 1);
    send_command(cmd);
    cmd.pos_x = -12'sd1;
    send_command(cmd);
    cmd.pos_x = 12'sd2047;
    cmd.pos_y = -12'sd2048;
    send_command(cmd);
    cmd = blank_command(MODE_READ);
    cmd.byte_address = 16'(RowBytes - 1);
    send_command(cmd);
    cmd.byte_address = 16'(StoreBytes - 1);
    send_command(cmd);
    cmd.byte_address = 16'(StoreBytes);
    send_command(cmd);
    cmd.byte_address = 16'hFFFF;
    send_command(cmd);
    // outlines: normal, zero width, negative height
    cmd = blank_command(MODE_RECT);
    cmd.pos_x = 12'sd3;
    cmd.pos_y = 12'sd2;
    cmd.rect_width = 12'sd6;
    cmd.rect_height = 12'sd4;
    send_command(cmd);
    cmd.rect_width = 12'sd0;
    send_command(cmd);
    cmd.rect_width = 12'sd5;
    cmd.rect_height = -12'sd3;
    send_command(cmd);
    // characters: drawn, scale zero, out of range codes
    cmd = blank_command(MODE_CHAR);
    cmd.pos_x = 12'sd20;
    cmd.pos_y = 12'sd10;
    cmd.char_code = 8'd65;
    cmd.scale = 4'd1;
    send_command(cmd);
    cmd.char_code = 8'd48;
    cmd.scale = 4'd0;
    send_command(cmd);
    cmd.char_code = 8'd31;
    send_command(cmd);
    cmd.char_code = 8'd91;
    send_command(cmd);
    cmd.char_code = 8'd255;
    send_command(cmd);
    cmd = blank_command(MODE_READ);
    cmd.byte_address = 16'd1102;
    send_command(cmd);
    send_command(blank_command(3'd5));
    send_command(blank_command(3'd6));
    send_command(blank_command(3'd7));
    // clear black, read, clear white
    send_command(blank_command(MODE_CLEAR));
    cmd = blank_command(MODE_READ);
    cmd.byte_address = 16'd777;
    send_command(cmd);
    cmd = blank_command(MODE_CLEAR);
    cmd.color = 1'b1;
    send_command(cmd);
  endtask

  task automatic run_rotation_sweep();
    logic [1:0] rot_order [4] = '{2'd3, 2'd1, 2'd2, 2'd0};
    foreach (rot_order[i]) begin
      write_rotation(rot_order[i]);
      repeat (45) send_command(random_command());
    end
  endtask

  task automatic run_idle_phases();
    int send_pct [4] = '{0, 65, 0, 37};
    int stall_rate [4] = '{0, 0, 65, 37};
    foreach (send_pct[i]) begin
      send_idle_pct = send_pct[i];
      stall_pct = stall_rate[i];
      write_rotation(2'($urandom_range(3)));
      repeat (130) send_command(random_command());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    rotation_q = '0;
    mismatches = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    clears_left = 4;
    foreach (frame_image[i]) frame_image[i] = 8'hFF;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_rotation_sweep();
    run_idle_phases();
    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hold a hard limit well above the slowest correct run
  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl
rtl/fgr_pkg.sv
rtl/fgr_pixel_writer.sv
rtl/framebuffer_glyph_rasterizer_core.sv
sim/tb_framebuffer_glyph_rasterizer_core.sv
